[design/beat_marker_sorted_table_top_defines.svh]
// Assertion macros for the beat marker table.
`ifndef BEAT_MARKER_SORTED_TABLE_TOP_DEFINES_SVH
`define BEAT_MARKER_SORTED_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BMST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define BMST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define BMST_ASSERT(lbl, clk, rst, prop)
`define BMST_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/bmst_pkg.sv]
// Shared types and constants of the beat marker table.
package bmst_pkg;
   localparam int SPB_W = 27;
   localparam int POS_W = 40;
   localparam int BEAT_W = 32;
   localparam int TGT_W = 48;
   localparam int CNT_OUT_W = 5;
   localparam int OP_W = 3;
   localparam int OUTC_W = 2;
   localparam int NUM_W = POS_W + 10;
   localparam int DEN_W = SPB_W + 1;
   localparam int MAX_MARKERS_DEF = 16;
   localparam logic [SPB_W-1:0] SPB_MIN = SPB_W'(256);
   localparam logic [SPB_W-1:0] SPB_RESET = SPB_W'(6144000);

   localparam logic [OP_W-1:0] OP_TOGGLE = 3'd0;
   localparam logic [OP_W-1:0] OP_TEST_BEAT = 3'd1;
   localparam logic [OP_W-1:0] OP_TEST_POS = 3'd2;
   localparam logic [OP_W-1:0] OP_NEXT = 3'd3;
   localparam logic [OP_W-1:0] OP_PREV = 3'd4;
   localparam logic [OP_W-1:0] OP_LOOP = 3'd5;

   localparam logic [OUTC_W-1:0] OUTC_NONE = 2'd0;
   localparam logic [OUTC_W-1:0] OUTC_REMOVED = 2'd1;
   localparam logic [OUTC_W-1:0] OUTC_INSERTED = 2'd2;
   localparam logic [OUTC_W-1:0] OUTC_FULL = 2'd3;

   typedef enum logic [1:0] {CELL_HOLD, CELL_INS, CELL_DEL} cell_cmd_type;

   typedef struct packed {
      logic gt;
      logic lt;
      logic eq;
      logic ge;
   } cell_flag_type;

   typedef struct packed {
      logic eq;
      logic nxt;
      logic [BEAT_W-1:0] next_val;
      logic [BEAT_W-1:0] prev_val;
      logic [BEAT_W-1:0] loop_val;
   } cell_sel_type;
endpackage

[design/bmst_req_if.sv]
// Request channel of the beat marker table.
interface bmst_req_if import bmst_pkg::*; ;
   logic valid;
   logic ready;
   logic [OP_W-1:0] op;
   logic [POS_W-1:0] position;
   logic [BEAT_W-1:0] beat;
   logic edit_blocked;
   modport source(output valid, op, position, beat, edit_blocked, input ready);
   modport sink(input valid, op, position, beat, edit_blocked, output ready);
endinterface

[design/bmst_rsp_if.sv]
// Response channel of the beat marker table.
interface bmst_rsp_if import bmst_pkg::*; ;
   logic valid;
   logic ready;
   logic found;
   logic [OUTC_W-1:0] outcome;
   logic [BEAT_W-1:0] beat_out;
   logic [TGT_W-1:0] target_position;
   logic [CNT_OUT_W-1:0] marker_count;
   modport source(output valid, found, outcome, beat_out, target_position, marker_count,
      input ready);
   modport sink(input valid, found, outcome, beat_out, target_position, marker_count,
      output ready);
endinterface

[design/beat_marker_sorted_table_top.sv]
// Top level of the beat marker table: control, cell chain, divider and multiplier.
//
// The req channel carries one operation per transfer: toggle, test beat, test position,
// next marker, previous marker or loop start. The rsp channel returns exactly one result
// per request. The csr port writes samples per beat (Q.8) whenever csr_wr_en is high.
// Operations that use a position first run a bit-serial divider; then the key is
// compared in every cell of the chain at once, the winning cell is picked, and a
// 32 by 27 bit multiplier forms the target position. Test beat and loop start skip
// the divider and go straight to the compare, evaluate, multiply and output states.
// One request is in work at a time; req.ready is high only while the block is idle,
// so no new request is taken before the last response has been accepted.
// A toggle shifts the part of the cell chain above the key by one place, all at once.
// Reset empties the table and sets spb_ff to 6144000 (Q.8); no clearing pass runs.
// While the receiver stalls the response stays in its register and no request is taken.
`include "beat_marker_sorted_table_top_defines.svh"
module beat_marker_sorted_table_top import bmst_pkg::*; #(
   parameter int MAX_MARKERS = MAX_MARKERS_DEF
) (
   input  logic clock,
   input  logic reset,
   bmst_req_if.sink req,
   bmst_rsp_if.source rsp,
   input  logic csr_wr_en,
   input  logic [SPB_W-1:0] csr_wr_data
);
   localparam int CNT_W = $clog2(MAX_MARKERS + 1);
   localparam int PROD_W = BEAT_W + SPB_W;

   typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_CMP, ST_EVAL, ST_MUL, ST_OUT} state_type;

   state_type state_ff;
   logic [SPB_W-1:0] spb_ff;
   logic [CNT_W-1:0] count_ff;
   logic [OP_W-1:0] op_ff;
   logic blocked_ff;
   logic [BEAT_W-1:0] key_ff;
   logic [BEAT_W-1:0] mop_ff;
   logic found_ff;
   logic [OUTC_W-1:0] outcome_ff;
   logic [BEAT_W-1:0] beat_out_ff;
   logic [TGT_W-1:0] target_ff;
   logic use_target_ff;

   logic [SPB_W-1:0] spb_eff;
   logic div_start;
   logic div_done;
   logic [BEAT_W-1:0] div_quot;
   logic [NUM_W-1:0] numer;
   logic [PROD_W-1:0] prod;
   cell_cmd_type cmd;

   cell_flag_type flag [MAX_MARKERS];
   logic [BEAT_W-1:0] vals [MAX_MARKERS];
   cell_sel_type sels [MAX_MARKERS];
   logic occ [MAX_MARKERS];

   logic any_eq;
   logic any_nxt;
   logic [BEAT_W-1:0] next_or;
   logic [BEAT_W-1:0] prev_or;
   logic [BEAT_W-1:0] loop_or;

   assign spb_eff = (spb_ff < SPB_MIN) ? SPB_MIN : spb_ff;
   assign numer = {req.position, 9'd0} + NUM_W'(spb_eff);
   assign prod = PROD_W'(mop_ff) * PROD_W'(spb_eff);

   bmst_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(numer), .denom({spb_eff, 1'b0}), .done(div_done), .quot(div_quot)
   );

   genvar g;
   generate
      for (g = 0; g < MAX_MARKERS; g++) begin : g_cell
         assign occ[g] = (CNT_W'(g) < count_ff);
         bmst_cell u_cell (
            .clock(clock), .cmd(cmd), .key(key_ff), .occ(occ[g]),
            .left_gt((g == 0) ? 1'b0 : flag[(g == 0) ? 0 : g - 1].gt),
            .left_val((g == 0) ? '0 : vals[(g == 0) ? 0 : g - 1]),
            .right_lt((g == MAX_MARKERS - 1) ? 1'b0
               : flag[(g == MAX_MARKERS - 1) ? g : g + 1].lt),
            .right_eq((g == MAX_MARKERS - 1) ? 1'b0
               : flag[(g == MAX_MARKERS - 1) ? g : g + 1].eq),
            .right_val((g == MAX_MARKERS - 1) ? '0
               : vals[(g == MAX_MARKERS - 1) ? g : g + 1]),
            .flag(flag[g]), .val(vals[g]), .sel(sels[g])
         );
      end
   endgenerate

   always_comb begin
      any_eq = 1'b0;
      any_nxt = 1'b0;
      next_or = '0;
      prev_or = '0;
      loop_or = '0;
      for (int i = 0; i < MAX_MARKERS; i++) begin
         any_eq = any_eq | sels[i].eq;
         any_nxt = any_nxt | sels[i].nxt;
         next_or = next_or | sels[i].next_val;
         prev_or = prev_or | sels[i].prev_val;
         loop_or = loop_or | sels[i].loop_val;
      end
   end

   always_comb begin
      cmd = CELL_HOLD;
      if (state_ff == ST_EVAL && op_ff == OP_TOGGLE && !blocked_ff) begin
         if (any_eq) begin
            cmd = CELL_DEL;
         end else if (count_ff < CNT_W'(MAX_MARKERS)) begin
            cmd = CELL_INS;
         end
      end
   end

   assign div_start = (state_ff == ST_IDLE) && req.valid && (req.op == OP_TOGGLE
      || req.op == OP_TEST_POS || req.op == OP_NEXT || req.op == OP_PREV);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         spb_ff <= SPB_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            spb_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  op_ff <= req.op;
                  blocked_ff <= req.edit_blocked;
                  key_ff <= req.beat;
                  state_ff <= div_start ? ST_DIV : ST_CMP;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  key_ff <= div_quot;
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               found_ff <= 1'b0;
               outcome_ff <= OUTC_NONE;
               beat_out_ff <= '0;
               use_target_ff <= 1'b0;
               mop_ff <= (op_ff == OP_NEXT) ? next_or : prev_or;
               unique case (op_ff)
                  OP_TOGGLE: begin
                     beat_out_ff <= key_ff;
                     if (!blocked_ff) begin
                        if (any_eq) begin
                           outcome_ff <= OUTC_REMOVED;
                           count_ff <= count_ff - 1'b1;
                        end else if (count_ff < CNT_W'(MAX_MARKERS)) begin
                           outcome_ff <= OUTC_INSERTED;
                           count_ff <= count_ff + 1'b1;
                        end else begin
                           outcome_ff <= OUTC_FULL;
                        end
                     end
                  end
                  OP_TEST_BEAT: found_ff <= any_eq;
                  OP_TEST_POS: begin
                     found_ff <= any_eq;
                     beat_out_ff <= key_ff;
                  end
                  OP_NEXT: begin
                     found_ff <= any_nxt;
                     beat_out_ff <= key_ff;
                     use_target_ff <= 1'b1;
                  end
                  OP_PREV: begin
                     found_ff <= (count_ff != '0);
                     beat_out_ff <= key_ff;
                     use_target_ff <= 1'b1;
                  end
                  OP_LOOP: begin
                     found_ff <= any_eq;
                     beat_out_ff <= any_eq ? loop_or : '0;
                  end
                  default: ;
               endcase
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (!use_target_ff) begin
                  target_ff <= '0;
               end else if (|prod[PROD_W-1:TGT_W]) begin
                  target_ff <= '1;
               end else begin
                  target_ff <= prod[TGT_W-1:0];
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.found = found_ff;
   assign rsp.outcome = outcome_ff;
   assign rsp.beat_out = beat_out_ff;
   assign rsp.target_position = target_ff;
   assign rsp.marker_count = CNT_OUT_W'(count_ff);

   `BMST_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_MARKERS))
   `BMST_ASSERT(a_count_only_eval, clock, reset, (state_ff != ST_EVAL) |=> $stable(count_ff))
   `BMST_ASSERT(a_out_done, clock, reset, (rsp.valid && rsp.ready) |=> (state_ff == ST_IDLE))
endmodule

[design/bmst_div.sv]
// Restoring divider that turns a position into a saturated beat, one bit per cycle.
module bmst_div import bmst_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic done,
   output logic [BEAT_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic busy_ff;
   logic done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] n_ff;
   logic [DEN_W-1:0] r_ff;
   logic [DEN_W-1:0] d_ff;
   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic bit_in;
   logic [DEN_W-1:0] r_in;

   always_comb begin
      trial = {r_ff, n_ff[NUM_W-1]};
      diff = trial - {1'b0, d_ff};
      bit_in = (trial >= {1'b0, d_ff});
      r_in = bit_in ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            n_ff <= numer;
            r_ff <= '0;
            d_ff <= denom;
         end else if (busy_ff) begin
            n_ff <= {n_ff[NUM_W-2:0], bit_in};
            r_ff <= r_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = (|n_ff[NUM_W-1:BEAT_W]) ? '1 : n_ff[BEAT_W-1:0];
endmodule

[design/bmst_cell.sv]
// One table cell: holds a marker, compares it with the key and shifts with its neighbors.
module bmst_cell import bmst_pkg::*; (
   input  logic clock,
   input  cell_cmd_type cmd,
   input  logic [BEAT_W-1:0] key,
   input  logic occ,
   input  logic left_gt,
   input  logic [BEAT_W-1:0] left_val,
   input  logic right_lt,
   input  logic right_eq,
   input  logic [BEAT_W-1:0] right_val,
   output cell_flag_type flag,
   output logic [BEAT_W-1:0] val,
   output cell_sel_type sel
);
   logic [BEAT_W-1:0] val_ff;
   logic [BEAT_W-1:0] val_in;
   cell_sel_type sel_ff;
   cell_sel_type sel_in;

   always_comb begin
      flag.gt = occ && (val_ff > key);
      flag.lt = occ && (val_ff < key);
      flag.eq = occ && (val_ff == key);
      flag.ge = occ && (val_ff >= key);
      sel_in.eq = flag.eq;
      sel_in.nxt = flag.gt && !left_gt;
      sel_in.next_val = (flag.gt && !left_gt) ? val_ff : '0;
      sel_in.prev_val = (flag.lt && !right_lt) ? val_ff : '0;
      sel_in.loop_val = (occ && right_eq) ? val_ff : '0;
      case (cmd)
         CELL_INS: val_in = (occ && !flag.gt) ? val_ff : (left_gt ? left_val : key);
         CELL_DEL: val_in = flag.ge ? right_val : val_ff;
         default:  val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      sel_ff <= sel_in;
   end

   assign val = val_ff;
   assign sel = sel_ff;
endmodule
